// ===== rtl/indexed_list_insert_delete_unit_assert.svh =====
// Assertion macros shared by the indexed list checker.
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ILID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed list check failed");

// Next-cycle implication, disabled while reset is held.
`define ILID_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed list check failed");

`endif

// ===== rtl/ilid_pkg.sv =====
// Types and constants of the indexed list unit.
package ilid_pkg;

    // Wide enough for any position or count at the largest supported capacity.
    localparam int POS_W = 11;

    localparam logic [2:0] FN_READ      = 3'd0;
    localparam logic [2:0] FN_INS_FRONT = 3'd1;
    localparam logic [2:0] FN_APPEND    = 3'd2;
    localparam logic [2:0] FN_INS_POS   = 3'd3;
    localparam logic [2:0] FN_DELETE    = 3'd4;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [6:0]         position;
        logic signed [31:0] value_in;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         count_out;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RDONE
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   pos;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

// ===== rtl/ilid_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors, and carries the read lane.
module ilid_cell #(
    parameter int INDEX = 0
) (
    input  logic                  i_clk,
    input  ilid_pkg::t_cell_ctl   i_ctl,
    input  logic signed [31:0]    i_left_entry,
    input  logic signed [31:0]    i_right_entry,
    input  logic signed [31:0]    i_right_lane,
    output logic signed [31:0]    o_entry,
    output logic signed [31:0]    o_lane
);

    localparam logic [ilid_pkg::POS_W-1:0] MY_IDX = ilid_pkg::POS_W'(INDEX);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;
    logic signed [31:0] r_lane;
    logic signed [31:0] n_lane;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            ilid_pkg::CELL_INS: begin
                if (MY_IDX == i_ctl.pos) begin
                    n_entry = i_ctl.value;
                end else if (MY_IDX > i_ctl.pos) begin
                    n_entry = i_left_entry;
                end
            end
            ilid_pkg::CELL_DEL: begin
                if (MY_IDX >= i_ctl.pos) begin
                    n_entry = i_right_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
        // The addressed slot drops its entry onto the lane, which drains toward slot zero.
        n_lane = (MY_IDX == i_ctl.pos) ? r_entry : i_right_lane;
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_lane  <= n_lane;
    end

    assign o_entry = r_entry;
    assign o_lane  = r_lane;

endmodule

// ===== rtl/indexed_list_insert_delete_unit.sv =====
// Indexed list unit: a bounded ordered list of signed 32-bit values in a row of slots.
//
// Input channel: i_in_valid / o_in_stall carry one request beat (func, position, value_in).
// Output channel: o_out_valid / i_out_stall carry one result beat per request
// (read_value, status, count_out), count_out being the count after the request.
// One request is in work at a time.
// Inserts, deletes, appends and every refused or out-of-range request finish at the
// accept edge: the result is valid in the next cycle and the next request can be taken
// in that same cycle, so these run at one request per cycle while the output drains.
// Inserts and deletes shift all slots at or after the position together, at the accept edge.
// A read of position p walks the read lane from slot p down to slot 0, one slot a cycle,
// counted down in S_READ: its result is registered from S_RDONE once the output is free,
// and the next request can be taken when the unit is back in S_IDLE.
// A result waiting under i_out_stall holds, and no new request is taken until it goes.
// Synchronous reset empties the list and drops any pending result; slot contents are
// left as they are and are never read before being written again.
module indexed_list_insert_delete_unit #(
    parameter int CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ilid_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ilid_pkg::t_out   o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    ilid_pkg::t_state    r_state;
    ilid_pkg::t_state    n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [6:0]          r_rd_pos;
    logic [6:0]          n_rd_pos;
    logic [6:0]          r_rd_cnt;
    logic [6:0]          n_rd_cnt;
    logic                r_out_valid;
    logic                n_out_valid;
    ilid_pkg::t_out      r_out;
    ilid_pkg::t_out      n_out;

    ilid_pkg::t_cell_ctl cell_ctl;
    logic                accept;
    logic                out_free;
    logic                full;
    logic [ilid_pkg::POS_W-1:0] cnt_ext;
    logic [ilid_pkg::POS_W-1:0] pos_ext;

    logic signed [31:0]  entry [CAPACITY];
    logic signed [31:0]  lane  [CAPACITY];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ilid_pkg::S_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(CAPACITY));
    assign cnt_ext    = ilid_pkg::POS_W'(r_count);
    assign pos_ext    = ilid_pkg::POS_W'(i_in.position);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_pos    = r_rd_pos;
        n_rd_cnt    = r_rd_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        cell_ctl.op    = ilid_pkg::CELL_HOLD;
        cell_ctl.pos   = ilid_pkg::POS_W'(r_rd_pos);
        cell_ctl.value = i_in.value_in;

        unique case (r_state)
            ilid_pkg::S_IDLE: begin
                cell_ctl.pos = pos_ext;
                if (accept) begin
                    n_out_valid      = 1'b1;
                    n_out.read_value = '0;
                    n_out.status     = ilid_pkg::STAT_DONE;
                    unique case (i_in.func) inside
                        ilid_pkg::FN_READ: begin
                            if (pos_ext < cnt_ext) begin
                                n_out_valid = 1'b0;
                                n_rd_pos    = i_in.position;
                                n_rd_cnt    = i_in.position;
                                n_state     = ilid_pkg::S_READ;
                            end else begin
                                n_out.read_value = -32'sd1;
                                n_out.status     = ilid_pkg::STAT_RANGE;
                            end
                        end
                        ilid_pkg::FN_INS_FRONT, ilid_pkg::FN_APPEND,
                        ilid_pkg::FN_INS_POS: begin
                            if (i_in.func == ilid_pkg::FN_INS_FRONT) begin
                                cell_ctl.pos = '0;
                            end else if (i_in.func == ilid_pkg::FN_APPEND) begin
                                cell_ctl.pos = cnt_ext;
                            end
                            // A positional insert past the end is refused before fullness.
                            if ((i_in.func == ilid_pkg::FN_INS_POS) && (pos_ext > cnt_ext)) begin
                                n_out.status = ilid_pkg::STAT_RANGE;
                            end else if (full) begin
                                n_out.status = ilid_pkg::STAT_FULL;
                            end else begin
                                cell_ctl.op = ilid_pkg::CELL_INS;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        ilid_pkg::FN_DELETE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_out.status = ilid_pkg::STAT_RANGE;
                            end else begin
                                cell_ctl.op = ilid_pkg::CELL_DEL;
                                n_count     = r_count - CW'(1);
                            end
                        end
                        default: begin
                            n_out.status = ilid_pkg::STAT_RANGE;
                        end
                    endcase
                    n_out.count_out = 7'(n_count);
                end
            end
            ilid_pkg::S_READ: begin
                if (r_rd_cnt == '0) begin
                    n_state = ilid_pkg::S_RDONE;
                end else begin
                    n_rd_cnt = r_rd_cnt - 7'd1;
                end
            end
            ilid_pkg::S_RDONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.read_value = lane[0];
                    n_out.status     = ilid_pkg::STAT_DONE;
                    n_out.count_out  = 7'(r_count);
                    n_state          = ilid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ilid_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ilid_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_rd_pos <= n_rd_pos;
        r_rd_cnt <= n_rd_cnt;
        r_out    <= n_out;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [31:0] left_entry;
            logic signed [31:0] right_entry;
            logic signed [31:0] right_lane;
            if (gi == 0) begin : g_first
                assign left_entry = '0;
            end else begin : g_mid_l
                assign left_entry = entry[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_entry = '0;
                assign right_lane  = '0;
            end else begin : g_mid_r
                assign right_entry = entry[gi+1];
                assign right_lane  = lane[gi+1];
            end
            ilid_cell #(
                .INDEX(gi)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (cell_ctl),
                .i_left_entry  (left_entry),
                .i_right_entry (right_entry),
                .i_right_lane  (right_lane),
                .o_entry       (entry[gi]),
                .o_lane        (lane[gi])
            );
        end
    endgenerate

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/ilid_check.sv =====
// Port-level checker for the indexed list unit, bound to the top level.
`include "indexed_list_insert_delete_unit_assert.svh"

module ilid_check #(
    parameter int CAPACITY = 64
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input ilid_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input ilid_pkg::t_out o_out
);

    `ILID_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

    // A result waiting under stall keeps the input side closed.
    `ILID_ASSERT_IMP(a_one_in_flight, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)

    // An out-of-range result reports either zero or minus one, the value of a bad read.
    `ILID_ASSERT_IMP(a_range_value, i_clk, i_rst_n, o_out_valid && (o_out.status == ilid_pkg::STAT_RANGE), (o_out.read_value == 32'sd0) || (o_out.read_value == -32'sd1))

    // A full-list refusal reports no value and a count equal to the capacity.
    `ILID_ASSERT_IMP(a_full_count, i_clk, i_rst_n, o_out_valid && (o_out.status == ilid_pkg::STAT_FULL), (o_out.read_value == 32'sd0) && (o_out.count_out == 7'(CAPACITY)))

endmodule

bind indexed_list_insert_delete_unit ilid_check #(.CAPACITY(CAPACITY)) u_ilid_check (.*);
